// ----- rtl/core/olide_pkg.sv -----
// ----------------------------------------------------------------------------
// olide_pkg
// Shared codes and types of the ordered list engine: command codes, status
// codes and the memory control group.
// ----------------------------------------------------------------------------
package olide_pkg;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;

	// command codes
	localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_RM_HEAD = 3'd1;
	localparam logic [FUNC_W-1:0] FN_RM_TAIL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RM_AT   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ_AT = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// memory port strobes
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

// ----- rtl/core/olide_ram.sv -----
// ----------------------------------------------------------------------------
// olide_ram
// Entry store of the list ring: one write port, one read port, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module olide_ram #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  olide_pkg::mem_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [DATA_WIDTH-1:0]      wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [DATA_WIDTH-1:0]      rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/olide_ctrl.sv -----
// ----------------------------------------------------------------------------
// olide_ctrl
// Command sequencer of the list engine: holds head and count, checks each
// command, drives the entry store and closes the gap on positional removal
// one entry per cycle.
// ----------------------------------------------------------------------------
module olide_ctrl #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [olide_pkg::FUNC_W-1:0]           func,
	input  logic signed [olide_pkg::VALUE_W-1:0]   value,
	input  logic [olide_pkg::POS_W-1:0]            position,
	output logic                                   done,
	output logic [olide_pkg::STATUS_W-1:0]         status,
	output logic signed [olide_pkg::VALUE_W-1:0]   item_value,
	output logic [$clog2(DEPTH+1)-1:0]             count_after,
	output olide_pkg::mem_ctl_t                    mem_ctl,
	output logic [$clog2(DEPTH)-1:0]               mem_waddr,
	output logic [DATA_WIDTH-1:0]                  mem_wdata,
	output logic [$clog2(DEPTH)-1:0]               mem_raddr,
	input  logic [DATA_WIDTH-1:0]                  mem_rdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KW    = CNT_W + 1;
	localparam int CMP_W = ((CNT_W > olide_pkg::POS_W) ? CNT_W : olide_pkg::POS_W) + 1;
	localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_READ  = 3'b010,
		S_SHIFT = 3'b100
	} state_t;

	state_t                             state_q, state_d;
	logic [IDX_W-1:0]                   head_q, head_d;
	logic [CNT_W-1:0]                   count_q, count_d;
	logic [IDX_W-1:0]                   k_q, k_d;
	logic [olide_pkg::FUNC_W-1:0]       func_q, func_d;
	logic                               done_q, done_d;
	logic [olide_pkg::STATUS_W-1:0]     status_q, status_d;
	logic [olide_pkg::VALUE_W-1:0]      item_q, item_d;
	logic [63:0]                        value_ext;
	logic [DATA_WIDTH-1:0]              store_word;
	logic [CMP_W-1:0]                   pos_x;
	logic [CMP_W-1:0]                   cnt_x;
	logic [CNT_W-1:0]                   count_dec;

	// ring index of list offset k
	function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] head,
	                                          input logic [IDX_W:0] k);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + k;
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[IDX_W-1:0];
	endfunction

	// stored word as seen on the 32-bit result port
	function automatic logic [olide_pkg::VALUE_W-1:0] report(input logic [DATA_WIDTH-1:0] w);
		logic [63:0] wide;
		wide = 64'(w);
		return wide[olide_pkg::VALUE_W-1:0];
	endfunction

	assign value_ext  = {{32{value[31]}}, value};
	assign store_word = value_ext[DATA_WIDTH-1:0];
	assign pos_x      = CMP_W'(position);
	assign cnt_x      = CMP_W'(count_q);
	assign count_dec  = count_q - ONE_C;

	// sequence commands
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		k_d       = k_q;
		func_d    = func_q;
		done_d    = 1'b0;
		status_d  = status_q;
		item_d    = item_q;
		mem_ctl   = '0;
		mem_waddr = '0;
		mem_wdata = store_word;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					func_d = func;
					case (func)
						olide_pkg::FN_APPEND: begin
							done_d = 1'b1;
							if (count_q == DEPTH_C) begin
								status_d = olide_pkg::ST_FULL;
								item_d   = '0;
							end else begin
								mem_ctl.we = 1'b1;
								mem_waddr  = ring(head_q, (IDX_W + 1)'(count_q));
								count_d    = count_q + ONE_C;
								status_d   = olide_pkg::ST_OK;
								item_d     = report(store_word);
							end
						end
						olide_pkg::FN_RM_HEAD, olide_pkg::FN_RM_TAIL,
						olide_pkg::FN_RM_AT, olide_pkg::FN_READ_AT: begin
							if (count_q == '0) begin
								done_d   = 1'b1;
								status_d = olide_pkg::ST_EMPTY;
								item_d   = '0;
							end else if ((func == olide_pkg::FN_RM_HEAD) ||
							             (func == olide_pkg::FN_RM_TAIL)) begin
								// offset of head or tail
								k_d = (func == olide_pkg::FN_RM_HEAD) ? '0
								      : IDX_W'(count_dec);
								mem_ctl.re = 1'b1;
								mem_raddr  = ring(head_q, {1'b0, k_d});
								state_d    = S_READ;
							end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
								done_d   = 1'b1;
								status_d = olide_pkg::ST_RANGE;
								item_d   = '0;
							end else begin
								k_d        = IDX_W'(position - 8'd1);
								mem_ctl.re = 1'b1;
								mem_raddr  = ring(head_q, {1'b0, k_d});
								state_d    = S_READ;
							end
						end
						default: begin
							// unused codes leave the list alone
							done_d   = 1'b1;
							status_d = olide_pkg::ST_OK;
							item_d   = '0;
						end
					endcase
				end
			end
			S_READ: begin
				status_d = olide_pkg::ST_OK;
				item_d   = report(mem_rdata);
				case (func_q)
					olide_pkg::FN_RM_HEAD: begin
						done_d  = 1'b1;
						count_d = count_dec;
						head_d  = (count_dec == '0) ? '0 : ring(head_q, (IDX_W + 1)'(1));
						state_d = S_IDLE;
					end
					olide_pkg::FN_RM_TAIL: begin
						done_d  = 1'b1;
						count_d = count_dec;
						head_d  = (count_dec == '0) ? '0 : head_q;
						state_d = S_IDLE;
					end
					olide_pkg::FN_RM_AT: begin
						if ((KW'(k_q) + KW'(1)) < KW'(count_q)) begin
							// fetch the entry that moves into the gap
							mem_ctl.re = 1'b1;
							mem_raddr  = ring(head_q, (IDX_W + 1)'(k_q) + (IDX_W + 1)'(1));
							state_d    = S_SHIFT;
						end else begin
							done_d  = 1'b1;
							count_d = count_dec;
							head_d  = (count_dec == '0) ? '0 : head_q;
							state_d = S_IDLE;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_SHIFT: begin
				// move entry k+1 down to k, fetch k+2, if it is live, in the same cycle
				mem_ctl.we = 1'b1;
				mem_waddr  = ring(head_q, (IDX_W + 1)'(k_q));
				mem_wdata  = mem_rdata;
				if ((KW'(k_q) + KW'(2)) < KW'(count_q)) begin
					mem_ctl.re = 1'b1;
					mem_raddr  = ring(head_q, (IDX_W + 1)'(k_q) + (IDX_W + 1)'(2));
					k_d        = k_q + IDX_W'(1);
				end else begin
					done_d  = 1'b1;
					count_d = count_dec;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		k_q      <= k_d;
		func_q   <= func_d;
		status_q <= status_d;
		item_q   <= item_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign item_value  = item_q;
	assign count_after = count_q;

endmodule

// ----- rtl/core/ordered_list_insert_delete_engine_core.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_engine_core
// Bounded circular list of signed words held in a ring memory: append at
// tail, remove head, remove tail, remove at position, read at position.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  command   start & !busy         func, value, position
//  result    done (one cycle)      status, item_value, count_after
//
//  Append, rejected and unused commands stay idle and never raise busy.
//  Remove head, remove tail and read pass through the read state (one
//  memory read). Remove at position reads too; if later entries remain, the
//  single write port then moves one entry per cycle to close the gap.
//  The result appears the cycle after the command finishes; it cannot stall.
//  Reset clears head and count; entry contents are undefined until written.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_engine_core #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [olide_pkg::FUNC_W-1:0]           func,
	input  logic signed [olide_pkg::VALUE_W-1:0]   value,
	input  logic [olide_pkg::POS_W-1:0]            position,
	output logic                                   done,
	output logic [olide_pkg::STATUS_W-1:0]         status,
	output logic signed [olide_pkg::VALUE_W-1:0]   item_value,
	output logic [$clog2(DEPTH+1)-1:0]             count_after
);

	localparam int IDX_W = $clog2(DEPTH);

	olide_pkg::mem_ctl_t    mem_ctl;
	logic [IDX_W-1:0]       mem_waddr;
	logic [DATA_WIDTH-1:0]  mem_wdata;
	logic [IDX_W-1:0]       mem_raddr;
	logic [DATA_WIDTH-1:0]  mem_rdata;

	// sequencer
	olide_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.value       (value),
		.position    (position),
		.done        (done),
		.status      (status),
		.item_value  (item_value),
		.count_after (count_after),
		.mem_ctl     (mem_ctl),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// entry store
	olide_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- rtl/core/olide_chk.sv -----
// ----------------------------------------------------------------------------
// olide_chk
// Port-level checks of the list engine: result consistency and command
// progress.
// ----------------------------------------------------------------------------
module olide_chk #(
	parameter int DEPTH = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   done,
	input logic [olide_pkg::STATUS_W-1:0]         status,
	input logic signed [olide_pkg::VALUE_W-1:0]   item_value,
	input logic [$clog2(DEPTH+1)-1:0]             count_after
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// count never exceeds the ring
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count_after <= CNT_W'(DEPTH)))
		else $error("count_after beyond depth");

	// rejected commands report a zero word
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != olide_pkg::ST_OK)) |-> (item_value == '0))
		else $error("nonzero item_value on rejected command");

	// an accepted command either finishes or holds busy next cycle
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command neither done nor busy");

	// full is only reported with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == olide_pkg::ST_FULL)) |-> (count_after == CNT_W'(DEPTH)))
		else $error("full status with list not full");

	// empty is only reported with an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == olide_pkg::ST_EMPTY)) |-> (count_after == '0))
		else $error("empty status with entries held");

endmodule

bind ordered_list_insert_delete_engine_core olide_chk #(
	.DEPTH (DEPTH)
) u_olide_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.item_value  (item_value),
	.count_after (count_after)
);

// ----- tb/sv/olide_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olide_result_checker
// Watches the command and result channels of the ordered list engine, keeps
// its own copy of the ring, predicts every result and compares it field by
// field. It hands the failure count and the number of results still owed
// to the testbench top.
// ----------------------------------------------------------------------------
module olide_result_checker
	import olide_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [FUNC_W-1:0]             func,
	input  logic signed [VALUE_W-1:0]     value,
	input  logic [POS_W-1:0]              position,
	input  logic                          done,
	input  logic [STATUS_W-1:0]           status,
	input  logic signed [VALUE_W-1:0]     item_value,
	input  logic [$clog2(DEPTH+1)-1:0]    count_after,
	output int                            mismatch_count,
	output int                            pending_results
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SLOT_W = $clog2(DEPTH);

	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic signed [VALUE_W-1:0]   item;
		logic [CNT_W-1:0]            count;
	} list_result_t;

	// shadow of the ring; slot indexes wrap at SLOT_W bits since DEPTH is 2**SLOT_W
	logic signed [VALUE_W-1:0] ring_words [DEPTH];
	logic [SLOT_W-1:0]         head_slot;
	int unsigned               live_count;
	list_result_t              expected_results [$];

	// apply one command to the shadow list and return the result it owes
	function automatic list_result_t apply_command(input logic [FUNC_W-1:0] f,
			input logic signed [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
		list_result_t r;
		r.status = ST_OK;
		r.item   = '0;
		if (f == FN_APPEND) begin
			if (live_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				ring_words[head_slot + live_count[SLOT_W-1:0]] = v;
				live_count++;
				r.item = v;
			end
		end else if (f > FN_READ_AT) begin
			// spare codes: no effect, plain ok result
		end else if (live_count == 0) begin
			r.status = ST_EMPTY;
		end else if (f == FN_RM_HEAD) begin
			r.item = ring_words[head_slot];
			head_slot++;
			live_count--;
		end else if (f == FN_RM_TAIL) begin
			r.item = ring_words[head_slot + SLOT_W'(live_count - 1)];
			live_count--;
		end else if (p == 0 || p > live_count) begin
			r.status = ST_RANGE;
		end else begin
			r.item = ring_words[head_slot + SLOT_W'(p - 1)];
			// close the gap: later entries move one slot toward the head
			if (f == FN_RM_AT) begin
				for (int k = p - 1; k + 1 < live_count; k++)
					ring_words[head_slot + SLOT_W'(k)] = ring_words[head_slot + SLOT_W'(k + 1)];
				live_count--;
			end
		end
		// an emptied list starts again at slot zero
		if (live_count == 0)
			head_slot = '0;
		r.count = CNT_W'(live_count);
		return r;
	endfunction

	// match results against the oldest expectation, then record new transfers
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			head_slot  = '0;
			live_count = 0;
			expected_results.delete();
			pending_results <= 0;
		end else begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("result with no command waiting: status %0d, item_value %0d, count_after %0d",
						status, item_value, count_after);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, status);
						mismatch_count++;
					end
					if (item_value !== want.item) begin
						$error("item_value mismatch: expected %0d, actual %0d",
							want.item, item_value);
						mismatch_count++;
					end
					if (count_after !== want.count) begin
						$error("count_after mismatch: expected %0d, actual %0d",
							want.count, count_after);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_command(func, value, position));
			pending_results <= expected_results.size();
		end
	end

endmodule

// ----- tb/sv/tb_ordered_list_insert_delete_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete_engine_core
// Drives commands into the ordered list engine: a directed pass over empty,
// bad positions and spare codes, then random fill and drain sequences
// under several sender idle rates. A checker beside the engine predicts and
// compares every result; this module only gives the verdict.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete_engine_core;

	import olide_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 1430;
	localparam int PHASE_ITEMS  = 360;
	localparam int DRAIN_CYCLES = 40;
	localparam int DRAIN_LIMIT  = 2000;

	// codes the engine leaves unused
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	logic                                clk      = 1'b0;
	logic                                arst_n   = 1'b0;
	logic                                start    = 1'b0;
	logic [FUNC_W-1:0]                   func     = '0;
	logic signed [VALUE_W-1:0]           value    = '0;
	logic [POS_W-1:0]                    position = '0;
	logic                                busy;
	logic                                done;
	logic [STATUS_W-1:0]                 status;
	logic signed [VALUE_W-1:0]           item_value;
	logic [$clog2(DEPTH+1)-1:0]          count_after;

	int mismatch_count;
	int pending_results;

	// stimulus shaping: occupancy estimate, fill/drain direction, idle rate
	int list_len = 0;
	bit filling  = 1'b1;
	int gap_pct  = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ordered_list_insert_delete_engine_core #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (32)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.value       (value),
		.position    (position),
		.done        (done),
		.status      (status),
		.item_value  (item_value),
		.count_after (count_after)
	);

	olide_result_checker #(
		.DEPTH (DEPTH)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.value           (value),
		.position        (position),
		.done            (done),
		.status          (status),
		.item_value      (item_value),
		.count_after     (count_after),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// issue one command, idling cycle by cycle at the current rate; return after the transfer
	task automatic issue_command(input logic [FUNC_W-1:0] f,
			input logic signed [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		func     <= f;
		value    <= v;
		position <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (f)
			FN_APPEND:              if (list_len < DEPTH) list_len++;
			FN_RM_HEAD, FN_RM_TAIL: if (list_len > 0) list_len--;
			FN_RM_AT:               if (p != 0 && p <= list_len) list_len--;
			default: ;
		endcase
	endtask

	// hold the sender until every owed result has arrived
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	// pick a command that walks the list between empty and full
	task automatic random_command();
		int pick;
		logic [FUNC_W-1:0] f;
		logic signed [VALUE_W-1:0] v;
		logic [POS_W-1:0] p;
		if (list_len == DEPTH)
			filling = 1'b0;
		else if (list_len == 0)
			filling = 1'b1;
		else if ($urandom_range(99) < 3)
			filling = !filling;

		pick = $urandom_range(99);
		if (pick < 4) begin
			f = FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
		end else if (pick < (filling ? 55 : 20)) begin
			f = FN_APPEND;
		end else begin
			case ($urandom_range(3))
				0:       f = FN_RM_HEAD;
				1:       f = FN_RM_TAIL;
				2:       f = FN_RM_AT;
				default: f = FN_READ_AT;
			endcase
		end

		// mostly random words, sometimes the extremes
		case ($urandom_range(15))
			0:       v = 32'sh8000_0000;
			1:       v = 32'sh7fff_ffff;
			2:       v = '0;
			3:       v = -32'sd1;
			default: v = $urandom;
		endcase

		// mostly live positions, some just out of range, a few anywhere
		pick = $urandom_range(99);
		if (pick < 85)
			p = POS_W'(list_len > 0 ? $urandom_range(list_len, 1) : 1);
		else if (pick < 95)
			p = POS_W'($urandom_range(1) ? list_len + 1 : 0);
		else
			p = POS_W'($urandom_range(255));

		issue_command(f, v, p);
	endtask

	initial begin
		int gap_table [4];
		int waited;
		gap_table = '{0, 79, 0, 38};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, empty wins over a bad position, spare code
		issue_command(FN_RM_HEAD, '0, '0);
		issue_command(FN_RM_TAIL, -32'sd1, 8'd255);
		issue_command(FN_RM_AT, '0, 8'd0);
		issue_command(FN_READ_AT, '0, 8'd255);
		issue_command(FN_SPARE_LO, 32'sh1234_5678, 8'd1);
		// extremes of the word
		issue_command(FN_APPEND, 32'sh8000_0000, '0);
		issue_command(FN_APPEND, 32'sh7fff_ffff, 8'd255);
		issue_command(FN_APPEND, '0, '0);
		issue_command(FN_APPEND, -32'sd1, '0);
		// position zero and beyond count, a spare code, then the first and last
		issue_command(FN_READ_AT, '0, 8'd0);
		issue_command(FN_READ_AT, '0, 8'd5);
		issue_command(FN_READ_AT, -32'sd1, 8'd255);
		issue_command(FN_SPARE_HI, -32'sd1, 8'd2);
		issue_command(FN_READ_AT, '0, 8'd1);
		issue_command(FN_READ_AT, '0, 8'd4);
		// remove in the middle, then at the tail position, then out of range
		issue_command(FN_RM_AT, '0, 8'd2);
		issue_command(FN_RM_AT, '0, 8'd3);
		issue_command(FN_RM_AT, '0, 8'd5);
		// drain to empty, head returns to slot zero
		issue_command(FN_RM_HEAD, '0, '0);
		issue_command(FN_RM_TAIL, '0, '0);
		issue_command(FN_APPEND, 32'sh5a5a_a5a5, '0);
		issue_command(FN_RM_AT, '0, 8'd1);

		// random part in phases of sender idle rate
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				settle();
				gap_pct = gap_table[(n / PHASE_ITEMS) % 4];
			end
			random_command();
		end

		// wait out owed results, then let stray ones show
		start  <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending_results != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/olide_pkg.sv
rtl/core/olide_ram.sv
rtl/core/olide_ctrl.sv
rtl/core/ordered_list_insert_delete_engine_core.sv
rtl/core/olide_chk.sv
tb/sv/olide_result_checker.sv
tb/sv/tb_ordered_list_insert_delete_engine_core.sv
